>>> rtl/core/lstm_pkg.sv
// ----------------------------------------------------------------------------
// lstm_pkg
// Shared command codes, register indexes and the tanh breakpoint table for
// the lstm layer forward block.
// ----------------------------------------------------------------------------
`default_nettype none

package lstm_pkg;

    // store select codes carried by cmd
    typedef enum logic [2:0] {
        CMD_WX   = 3'd0,
        CMD_WH   = 3'd1,
        CMD_BIAS = 3'd2,
        CMD_H0   = 3'd3,
        CMD_C0   = 3'd4,
        CMD_X    = 3'd5
    } cmd_t;

    // configuration register indexes
    localparam logic [2:0] CFG_USE_BIAS    = 3'd0;
    localparam logic [2:0] CFG_HIDDEN_SIZE = 3'd1;
    localparam logic [2:0] CFG_INPUT_SIZE  = 3'd2;
    localparam logic [2:0] CFG_BATCH_COUNT = 3'd3;

    // tanh at multiples of 0.5 over [0,8], unsigned Q16
    function automatic logic [16:0] tanh_q16(input logic [4:0] i);
        logic [16:0] r;
        case (i)
            5'd0:    r = 17'd0;
            5'd1:    r = 17'd30285;
            5'd2:    r = 17'd49912;
            5'd3:    r = 17'd59320;
            5'd4:    r = 17'd63179;
            5'd5:    r = 17'd64659;
            5'd6:    r = 17'd65212;
            5'd7:    r = 17'd65417;
            5'd8:    r = 17'd65492;
            5'd9:    r = 17'd65520;
            5'd10:   r = 17'd65530;
            5'd11:   r = 17'd65534;
            5'd12:   r = 17'd65535;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/lstm_layer_forward.sv
// ----------------------------------------------------------------------------
// lstm_layer_forward
// LSTM layer forward pass in signed fixed point, one time step per x item
// marked last, with all state and weights held in on-chip memories.
// ----------------------------------------------------------------------------
// Usage: an item (cmd, index, value, last) is taken when start is high and
// busy is low. Commands 0..4 load input weights, recurrent weights, biases
// and the initial hidden and cell state; command 5 loads an x element, and
// with last set it also runs one time step.
// A step walks the jobs (unit p, sequence b) one at a time. For each gate a
// single multiply-accumulate unit streams ni input and nh recurrent products
// from the weight memories, one per cycle. Activations, the cell update and
// the hidden product follow on a shared piecewise-linear unit.
// The weight memory read port (one product a cycle) sets the pace of a step.
// Results: one hidden value per job in unit-major order, each shown for one
// cycle with valid high; end_of_step marks the last. The receiver cannot
// stall. New hidden values are copied into the hidden store at step end.
// Reset: registers take their reset values, hidden and cell state read as
// zero through per-entry valid bits; weights and x are undefined until
// written. Configuration writes (cfg_write) take effect at once; the user
// must make them only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module lstm_layer_forward #(
    parameter int HIDDEN    = 32,
    parameter int INPUTS    = 32,
    parameter int BATCH     = 2,
    parameter int FRAC_BITS = 12
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [5:0]         cfg_data,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         cmd,
    input  wire logic [11:0]        index,
    input  wire logic signed [15:0] value,
    input  wire logic               last,
    output logic                    valid,
    output logic signed [15:0]      hidden_value,
    output logic [4:0]              unit_index,
    output logic                    batch_index,
    output logic                    end_of_step
);

    localparam int WX_DEPTH = 4 * HIDDEN * INPUTS;
    localparam int WH_DEPTH = 4 * HIDDEN * HIDDEN;
    localparam int BI_DEPTH = 4 * HIDDEN;
    localparam int HC_DEPTH = HIDDEN * BATCH;
    localparam int XB_DEPTH = INPUTS * BATCH;
    localparam int WX_AW    = $clog2(WX_DEPTH);
    localparam int WH_AW    = $clog2(WH_DEPTH);
    localparam int BI_AW    = $clog2(BI_DEPTH);
    localparam int HC_AW    = (HC_DEPTH > 1) ? $clog2(HC_DEPTH) : 1;
    localparam int XB_AW    = (XB_DEPTH > 1) ? $clog2(XB_DEPTH) : 1;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_MAC   = 13'b0000000000010,
        S_DRAIN = 13'b0000000000100,
        S_GSUM  = 13'b0000000001000,
        S_ACTA  = 13'b0000000010000,
        S_ACTB  = 13'b0000000100000,
        S_CELL1 = 13'b0000001000000,
        S_CELL2 = 13'b0000010000000,
        S_CELL3 = 13'b0000100000000,
        S_HID1  = 13'b0001000000000,
        S_HID2  = 13'b0010000000000,
        S_COPY  = 13'b0100000000000,
        S_CFIN  = 13'b1000000000000
    } state_t;

    // round half up to FRAC_BITS and saturate to 16 bits
    function automatic logic signed [15:0] rnd_sat(input logic signed [39:0] v);
        logic signed [39:0] t;
        t = (v + (40'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > 40'sd32767)
            return 16'sh7fff;
        else if (t < -40'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    state_t state_reg, state_next;

    logic       use_bias_reg;
    logic [5:0] hidden_size_reg;
    logic [5:0] input_size_reg;
    logic [1:0] batch_count_reg;

    logic [5:0]       nh_reg, ni_reg;
    logic             nb2_reg;
    logic [6:0]       mn_reg;
    logic [10:0]      hi_reg, hh_reg;
    logic [5:0]       p_reg, k_reg;
    logic             b_reg, ph_reg;
    logic [6:0]       j_reg, cp_reg;
    logic [1:0]       g_reg;
    logic [2:0]       sel_reg;
    logic             drn_reg;
    logic [WX_AW-1:0] rowx_reg, gx_reg;
    logic [WH_AW-1:0] rowh_reg, gh_reg;
    logic [BI_AW-1:0] gb_reg;
    logic             v1_reg, ph1_reg, v2_reg, cpv_reg;
    logic [HC_AW-1:0] cpa_reg;
    logic             hv_rd_reg, cv_rd_reg;
    logic             hval_reg [HC_DEPTH];
    logic             cval_reg [HC_DEPTH];
    logic             valid_reg;

    // memories and their registered read data
    logic signed [15:0] wx_mem [WX_DEPTH];
    logic signed [15:0] wh_mem [WH_DEPTH];
    logic signed [15:0] bi_mem [BI_DEPTH];
    logic signed [15:0] x_mem  [XB_DEPTH];
    logic signed [15:0] h_mem  [HC_DEPTH];
    logic signed [15:0] c_mem  [HC_DEPTH];
    logic signed [15:0] pd_mem [HC_DEPTH];
    logic signed [15:0] wx_rd, wh_rd, bi_rd, x_rd, h_rd, c_rd, pd_rd;

    // datapath registers
    logic signed [31:0] prod_reg;
    logic signed [39:0] acc_reg;
    logic signed [15:0] gate_reg [4];
    logic signed [17:0] actv_reg [5];
    logic signed [35:0] m1_reg, m2_reg;
    logic signed [15:0] c_reg;
    logic [30:0]        am_reg;
    logic [16:0]        lo_reg;
    logic               sat_reg, neg_reg, sig_reg;
    logic signed [15:0] hidden_value_reg;
    logic [4:0]         unit_index_reg;
    logic               batch_index_reg, end_of_step_reg;

    // ------------------------------------------------------------------
    // handshake, sizes
    logic accept, ld_wx, ld_wh, ld_bi, ld_h, ld_c, ld_x, go;
    logic [5:0] nh_c, ni_c;
    logic [1:0] nb_c;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign ld_wx  = accept && (cmd == lstm_pkg::CMD_WX) && ({1'b0, index} < 13'(WX_DEPTH));
    assign ld_wh  = accept && (cmd == lstm_pkg::CMD_WH) && ({1'b0, index} < 13'(WH_DEPTH));
    assign ld_bi  = accept && (cmd == lstm_pkg::CMD_BIAS) && ({1'b0, index} < 13'(BI_DEPTH));
    assign ld_h   = accept && (cmd == lstm_pkg::CMD_H0) && ({1'b0, index} < 13'(HC_DEPTH));
    assign ld_c   = accept && (cmd == lstm_pkg::CMD_C0) && ({1'b0, index} < 13'(HC_DEPTH));
    assign ld_x   = accept && (cmd == lstm_pkg::CMD_X) && ({1'b0, index} < 13'(XB_DEPTH));
    assign go     = accept && (cmd == lstm_pkg::CMD_X) && last;

    always_comb
    begin
        nh_c = hidden_size_reg;
        if (hidden_size_reg == 6'd0)
            nh_c = 6'd1;
        else if (hidden_size_reg > 6'(HIDDEN))
            nh_c = 6'(HIDDEN);
        ni_c = input_size_reg;
        if (input_size_reg == 6'd0)
            ni_c = 6'd1;
        else if (input_size_reg > 6'(INPUTS))
            ni_c = 6'(INPUTS);
        nb_c = batch_count_reg;
        if (batch_count_reg == 2'd0)
            nb_c = 2'd1;
        else if (batch_count_reg > 2'(BATCH))
            nb_c = 2'(BATCH);
    end

    // ------------------------------------------------------------------
    // read addresses
    logic [6:0]       x_ra_w, h_ra_w;
    logic [XB_AW-1:0] x_ra;
    logic [HC_AW-1:0] h_ra, j_a;
    logic [WX_AW-1:0] wx_ra;
    logic [WH_AW-1:0] wh_ra;

    assign x_ra_w = nb2_reg ? {k_reg, b_reg} : {1'b0, k_reg};
    assign h_ra_w = x_ra_w;
    assign x_ra   = x_ra_w[XB_AW-1:0];
    assign h_ra   = h_ra_w[HC_AW-1:0];
    assign j_a    = j_reg[HC_AW-1:0];
    assign wx_ra  = gx_reg + WX_AW'(k_reg);
    assign wh_ra  = gh_reg + WH_AW'(k_reg);

    always_ff @(posedge clk)
    begin
        if (ld_wx)
            wx_mem[index[WX_AW-1:0]] <= value;
        wx_rd <= wx_mem[wx_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ld_wh)
            wh_mem[index[WH_AW-1:0]] <= value;
        wh_rd <= wh_mem[wh_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ld_bi)
            bi_mem[index[BI_AW-1:0]] <= value;
        bi_rd <= bi_mem[gb_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ld_x)
            x_mem[index[XB_AW-1:0]] <= value;
        x_rd <= x_mem[x_ra];
    end

    // hidden store: loads while idle, copy of new values at step end
    always_ff @(posedge clk)
    begin
        if (ld_h)
            h_mem[index[HC_AW-1:0]] <= value;
        else if (cpv_reg)
            h_mem[cpa_reg] <= pd_rd;
        h_rd <= h_mem[h_ra];
    end

    // cell store: in-place update, one entry per job
    logic signed [15:0] c_new;
    assign c_new = rnd_sat(40'(m1_reg) + 40'(m2_reg));

    always_ff @(posedge clk)
    begin
        if (ld_c)
            c_mem[index[HC_AW-1:0]] <= value;
        else if (state_reg == S_CELL3)
            c_mem[j_a] <= c_new;
        c_rd <= c_mem[j_a];
    end

    // pending new hidden values
    logic signed [15:0] h_new;
    assign h_new = rnd_sat(40'(m1_reg));

    always_ff @(posedge clk)
    begin
        if (state_reg == S_HID2)
            pd_mem[j_a] <= h_new;
        pd_rd <= pd_mem[cp_reg[HC_AW-1:0]];
    end

    // ------------------------------------------------------------------
    // activation unit, first half: segment lookup and slope product
    logic signed [15:0] act_x;
    logic               act_sig;
    logic [16:0]        act_a, seg, fr, lo_w, hi_w, d_w;
    logic [4:0]         si;

    always_comb
    begin
        act_x   = (sel_reg == 3'd4) ? c_reg : gate_reg[sel_reg[1:0]];
        act_sig = (sel_reg != 3'd2) && (sel_reg != 3'd4);
        act_a   = act_x[15] ? (17'd0 - {1'b1, act_x}) : {1'b0, act_x};
        if (act_sig)
        begin
            seg = act_a >> FRAC_BITS;
            fr  = act_a & 17'((1 << FRAC_BITS) - 1);
        end
        else
        begin
            seg = act_a >> (FRAC_BITS - 1);
            fr  = act_a & 17'((1 << (FRAC_BITS - 1)) - 1);
        end
        si   = {1'b0, seg[3:0]};
        lo_w = lstm_pkg::tanh_q16(si);
        hi_w = lstm_pkg::tanh_q16(si + 5'd1);
        d_w  = hi_w - lo_w;
    end

    // activation unit, second half: rounding and tanh / sigmoid form
    logic [30:0]        rs, rt;
    logic [16:0]        t_w;
    logic [17:0]        tr, sg;
    logic signed [17:0] act_res;

    always_comb
    begin
        rs  = (am_reg + 31'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        rt  = (am_reg + 31'(1 << (FRAC_BITS - 2))) >> (FRAC_BITS - 1);
        t_w = sat_reg ? 17'd65536 : lo_reg + 17'(sig_reg ? rs : rt);
        tr  = (18'(t_w) + 18'(1 << (15 - FRAC_BITS))) >> (16 - FRAC_BITS);
        sg  = neg_reg ? (18'd65536 - 18'(t_w)) : (18'd65536 + 18'(t_w));
        sg  = (sg + 18'(1 << (16 - FRAC_BITS))) >> (17 - FRAC_BITS);
        if (sig_reg)
            act_res = $signed(sg);
        else
            act_res = neg_reg ? -$signed(tr) : $signed(tr);
    end

    // ------------------------------------------------------------------
    // sequencer
    logic last_x, last_h, last_job, last_cp;
    assign last_x   = (k_reg == ni_reg - 6'd1);
    assign last_h   = (k_reg == nh_reg - 6'd1);
    assign last_job = (j_reg == mn_reg - 7'd1);
    assign last_cp  = (cp_reg == mn_reg - 7'd1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (go) state_next = S_MAC;
            S_MAC:   if (ph_reg && last_h) state_next = S_DRAIN;
            S_DRAIN: if (drn_reg) state_next = S_GSUM;
            S_GSUM:  state_next = (g_reg == 2'd3) ? S_ACTA : S_MAC;
            S_ACTA:  state_next = S_ACTB;
            S_ACTB:
            begin
                if (sel_reg == 3'd3)
                    state_next = S_CELL1;
                else if (sel_reg == 3'd4)
                    state_next = S_HID1;
                else
                    state_next = S_ACTA;
            end
            S_CELL1: state_next = S_CELL2;
            S_CELL2: state_next = S_CELL3;
            S_CELL3: state_next = S_ACTA;
            S_HID1:  state_next = S_HID2;
            S_HID2:  state_next = last_job ? S_COPY : S_MAC;
            S_COPY:  if (last_cp) state_next = S_CFIN;
            S_CFIN:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // next row offsets when the unit advances
    logic             adv_p;
    logic [WX_AW-1:0] rowx_n;
    logic [WH_AW-1:0] rowh_n;
    assign adv_p  = !(nb2_reg && !b_reg);
    assign rowx_n = adv_p ? rowx_reg + WX_AW'(ni_reg) : rowx_reg;
    assign rowh_n = adv_p ? rowh_reg + WH_AW'(nh_reg) : rowh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            use_bias_reg    <= 1'b1;
            hidden_size_reg <= 6'd32;
            input_size_reg  <= 6'd32;
            batch_count_reg <= 2'd2;
            nh_reg   <= 6'd1;
            ni_reg   <= 6'd1;
            nb2_reg  <= 1'b0;
            mn_reg   <= 7'd1;
            hi_reg   <= '0;
            hh_reg   <= '0;
            p_reg    <= '0;
            k_reg    <= '0;
            b_reg    <= 1'b0;
            ph_reg   <= 1'b0;
            j_reg    <= '0;
            cp_reg   <= '0;
            g_reg    <= '0;
            sel_reg  <= '0;
            drn_reg  <= 1'b0;
            rowx_reg <= '0;
            rowh_reg <= '0;
            gx_reg   <= '0;
            gh_reg   <= '0;
            gb_reg   <= '0;
            v1_reg   <= 1'b0;
            ph1_reg  <= 1'b0;
            v2_reg   <= 1'b0;
            cpv_reg  <= 1'b0;
            cpa_reg  <= '0;
            hv_rd_reg <= 1'b0;
            cv_rd_reg <= 1'b0;
            valid_reg <= 1'b0;
            for (int i = 0; i < HC_DEPTH; i++)
            begin
                hval_reg[i] <= 1'b0;
                cval_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_write)
            begin
                case (cfg_index)
                    lstm_pkg::CFG_USE_BIAS:    use_bias_reg    <= cfg_data[0];
                    lstm_pkg::CFG_HIDDEN_SIZE: hidden_size_reg <= cfg_data;
                    lstm_pkg::CFG_INPUT_SIZE:  input_size_reg  <= cfg_data;
                    lstm_pkg::CFG_BATCH_COUNT: batch_count_reg <= cfg_data[1:0];
                    default: ;
                endcase
            end

            // valid bits of hidden and cell state
            if (ld_h)
                hval_reg[index[HC_AW-1:0]] <= 1'b1;
            if (cpv_reg)
                hval_reg[cpa_reg] <= 1'b1;
            if (ld_c)
                cval_reg[index[HC_AW-1:0]] <= 1'b1;
            if (state_reg == S_CELL3)
                cval_reg[j_a] <= 1'b1;
            hv_rd_reg <= hval_reg[h_ra];
            cv_rd_reg <= cval_reg[j_a];

            // product pipeline control
            v1_reg    <= (state_reg == S_MAC);
            ph1_reg   <= ph_reg;
            v2_reg    <= v1_reg;
            cpv_reg   <= (state_reg == S_COPY);
            cpa_reg   <= cp_reg[HC_AW-1:0];
            valid_reg <= (state_reg == S_HID2);

            case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        nh_reg   <= nh_c;
                        ni_reg   <= ni_c;
                        nb2_reg  <= (nb_c == 2'd2);
                        mn_reg   <= 7'({1'b0, nh_c} * {5'b0, nb_c});
                        hi_reg   <= 11'({5'b0, nh_c} * {5'b0, ni_c});
                        hh_reg   <= 11'({5'b0, nh_c} * {5'b0, nh_c});
                        p_reg    <= '0;
                        b_reg    <= 1'b0;
                        j_reg    <= '0;
                        g_reg    <= '0;
                        k_reg    <= '0;
                        ph_reg   <= 1'b0;
                        rowx_reg <= '0;
                        rowh_reg <= '0;
                        gx_reg   <= '0;
                        gh_reg   <= '0;
                        gb_reg   <= '0;
                    end
                end
                S_MAC:
                begin
                    if (!ph_reg && last_x)
                    begin
                        ph_reg <= 1'b1;
                        k_reg  <= '0;
                    end
                    else
                        k_reg <= k_reg + 6'd1;
                    drn_reg <= 1'b0;
                end
                S_DRAIN: drn_reg <= 1'b1;
                S_GSUM:
                begin
                    g_reg   <= g_reg + 2'd1;
                    gx_reg  <= gx_reg + WX_AW'(hi_reg);
                    gh_reg  <= gh_reg + WH_AW'(hh_reg);
                    gb_reg  <= gb_reg + BI_AW'(nh_reg);
                    k_reg   <= '0;
                    ph_reg  <= 1'b0;
                    sel_reg <= '0;
                end
                S_ACTB:
                begin
                    if (sel_reg < 3'd3)
                        sel_reg <= sel_reg + 3'd1;
                end
                S_CELL3: sel_reg <= 3'd4;
                S_HID2:
                begin
                    if (last_job)
                        cp_reg <= '0;
                    else
                    begin
                        j_reg    <= j_reg + 7'd1;
                        b_reg    <= adv_p ? 1'b0 : 1'b1;
                        p_reg    <= adv_p ? p_reg + 6'd1 : p_reg;
                        rowx_reg <= rowx_n;
                        rowh_reg <= rowh_n;
                        gx_reg   <= rowx_n;
                        gh_reg   <= rowh_n;
                        gb_reg   <= BI_AW'(adv_p ? p_reg + 6'd1 : p_reg);
                        g_reg    <= '0;
                        k_reg    <= '0;
                        ph_reg   <= 1'b0;
                    end
                end
                S_COPY: cp_reg <= cp_reg + 7'd1;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // datapath
    logic signed [15:0] h_op, c_old;
    logic signed [39:0] acc_b;
    assign h_op  = hv_rd_reg ? h_rd : 16'sd0;
    assign c_old = cv_rd_reg ? c_rd : 16'sd0;
    assign acc_b = acc_reg + (use_bias_reg ? (40'(bi_rd) <<< FRAC_BITS) : 40'sd0);

    always_ff @(posedge clk)
    begin
        // multiply then accumulate
        prod_reg <= ph1_reg ? (32'(wh_rd) * 32'(h_op)) : (32'(wx_rd) * 32'(x_rd));
        if ((state_reg == S_IDLE) || (state_reg == S_GSUM))
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= acc_reg + 40'(prod_reg);

        if (state_reg == S_GSUM)
            gate_reg[g_reg] <= rnd_sat(acc_b);

        // activation halves
        if (state_reg == S_ACTA)
        begin
            am_reg  <= 31'(d_w) * 31'(fr);
            lo_reg  <= lo_w;
            sat_reg <= (seg >= 17'd16);
            neg_reg <= act_x[15];
            sig_reg <= act_sig;
        end
        if (state_reg == S_ACTB)
            actv_reg[sel_reg] <= act_res;

        // cell and hidden products
        case (state_reg)
            S_CELL1: m1_reg <= 36'(actv_reg[0]) * 36'(c_old);
            S_CELL2: m2_reg <= 36'(actv_reg[1]) * 36'(actv_reg[2]);
            S_HID1:  m1_reg <= 36'(actv_reg[3]) * 36'(actv_reg[4]);
            default: ;
        endcase
        if (state_reg == S_CELL3)
            c_reg <= c_new;

        // result item
        if (state_reg == S_HID2)
        begin
            hidden_value_reg <= h_new;
            unit_index_reg   <= p_reg[4:0];
            batch_index_reg  <= b_reg;
            end_of_step_reg  <= last_job;
        end
    end

    assign valid        = valid_reg;
    assign hidden_value = hidden_value_reg;
    assign unit_index   = unit_index_reg;
    assign batch_index  = batch_index_reg;
    assign end_of_step  = end_of_step_reg;

endmodule

`default_nettype wire

>>> sim/lstm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lstm_checker
// Watches the command, configuration and result ports of the lstm layer
// block, keeps its own copy of weights, state and registers, predicts every
// hidden value of a time step and compares each result in order.
// ----------------------------------------------------------------------------
module lstm_checker
    import lstm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [5:0]         cfg_data,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [2:0]         cmd,
    input  wire logic [11:0]        index,
    input  wire logic signed [15:0] value,
    input  wire logic               last,
    input  wire logic               valid,
    input  wire logic signed [15:0] hidden_value,
    input  wire logic [4:0]         unit_index,
    input  wire logic               batch_index,
    input  wire logic               end_of_step,
    output int                      fail_count,
    output int                      pending
);

    localparam int FB = 12;

    typedef struct {
        logic signed [15:0] h;
        logic [4:0]         unit;
        logic               seq;
        logic               eos;
    } hidden_out_t;

    // tanh breakpoints at multiples of 0.5, unsigned Q16
    localparam int unsigned TANH_PTS [0:16] = '{
        0, 30285, 49912, 59320, 63179, 64659, 65212, 65417, 65492,
        65520, 65530, 65534, 65535, 65536, 65536, 65536, 65536
    };

    logic signed [15:0] wx_mem [0:4095];
    logic signed [15:0] wh_mem [0:4095];
    logic signed [15:0] bias_mem [0:127];
    logic signed [15:0] h_mem [0:63];
    logic signed [15:0] c_mem [0:63];
    logic signed [15:0] x_mem [0:63];
    logic        use_bias_r;
    logic [5:0]  hidden_r, input_r;
    logic [1:0]  batch_r;
    hidden_out_t expected_q [$];

    assign pending = expected_q.size();

    function automatic longint round_fx(input longint v);
        return (v + (longint'(1) <<< (FB - 1))) >>> FB;
    endfunction

    function automatic int sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    // interpolated tanh of a magnitude with fb fraction bits, Q16
    function automatic int unsigned tanh_mag(input int unsigned a, input int fb);
        int unsigned seg, fr, lo, d;
        seg = a >> (fb - 1);
        if (seg >= 16) return 65536;
        fr = a & ((32'd1 << (fb - 1)) - 1);
        lo = TANH_PTS[seg];
        d = TANH_PTS[seg + 1] - lo;
        return lo + int'((longint'(d) * fr + (longint'(1) << (fb - 2))) >> (fb - 1));
    endfunction

    function automatic int tanh_q(input int x);
        int unsigned a, r;
        a = x < 0 ? -x : x;
        r = (tanh_mag(a, FB) + (1 << (15 - FB))) >> (16 - FB);
        return x < 0 ? -int'(r) : int'(r);
    endfunction

    function automatic int sigmoid_q(input int x);
        int unsigned a, t, s;
        a = x < 0 ? -x : x;
        t = tanh_mag(a, FB + 1);
        s = x < 0 ? 65536 - t : 65536 + t;
        return int'((s + (1 << (16 - FB))) >> (17 - FB));
    endfunction

    // one time step over all (unit, sequence) jobs
    task automatic run_step();
        int nh, ni, nb, j, f, ig, cw, o, cn;
        int gate [4];
        longint acc;
        logic signed [15:0] nh_v [0:63];
        logic signed [15:0] nc_v [0:63];
        hidden_out_t e;
        nh = hidden_r == 0 ? 1 : (hidden_r > 32 ? 32 : hidden_r);
        ni = input_r == 0 ? 1 : (input_r > 32 ? 32 : input_r);
        nb = batch_r == 0 ? 1 : (batch_r > 2 ? 2 : batch_r);
        for (int p = 0; p < nh; p++)
        begin
            for (int b = 0; b < nb; b++)
            begin
                j = p * nb + b;
                for (int g = 0; g < 4; g++)
                begin
                    acc = 0;
                    for (int k = 0; k < ni; k++)
                        acc += longint'(wx_mem[g*nh*ni + p*ni + k]) * longint'(x_mem[k*nb + b]);
                    for (int k = 0; k < nh; k++)
                        acc += longint'(wh_mem[g*nh*nh + p*nh + k]) * longint'(h_mem[k*nb + b]);
                    if (use_bias_r)
                        acc += longint'(bias_mem[g*nh + p]) <<< FB;
                    gate[g] = sat16(round_fx(acc));
                end
                f  = sigmoid_q(gate[0]);
                ig = sigmoid_q(gate[1]);
                cw = tanh_q(gate[2]);
                o  = sigmoid_q(gate[3]);
                cn = sat16(round_fx(longint'(f) * longint'(c_mem[j]) + longint'(ig) * cw));
                nc_v[j] = cn[15:0];
                nh_v[j] = 16'(sat16(round_fx(longint'(o) * tanh_q(cn))));
            end
        end
        for (j = 0; j < nh * nb; j++)
        begin
            h_mem[j] = nh_v[j];
            c_mem[j] = nc_v[j];
            e.h = nh_v[j];
            e.unit = 5'(j / nb);
            e.seq = 1'(j % nb);
            e.eos = (j + 1 == nh * nb);
            expected_q.push_back(e);
        end
    endtask

    // prediction on accepted items and register writes, comparison on results
    always @(posedge clk or negedge rst_n)
    begin
        hidden_out_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < 4096; i++)
            begin
                wx_mem[i] = '0;
                wh_mem[i] = '0;
            end
            for (int i = 0; i < 128; i++)
                bias_mem[i] = '0;
            for (int i = 0; i < 64; i++)
            begin
                h_mem[i] = '0;
                c_mem[i] = '0;
                x_mem[i] = '0;
            end
            use_bias_r = 1'b1;
            hidden_r = 6'd32;
            input_r = 6'd32;
            batch_r = 2'd2;
            fail_count = 0;
            expected_q.delete();
        end
        else
        begin
            if (valid)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result h=%0d unit=%0d seq=%0d eos=%0d",
                             $time, hidden_value, unit_index, batch_index, end_of_step);
                    fail_count++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (hidden_value !== e.h || unit_index !== e.unit ||
                        batch_index !== e.seq || end_of_step !== e.eos)
                    begin
                        $display("%0t: mismatch expected h=%0d unit=%0d seq=%0d eos=%0d",
                                 $time, e.h, e.unit, e.seq, e.eos);
                        $display("%0t:          actual   h=%0d unit=%0d seq=%0d eos=%0d",
                                 $time, hidden_value, unit_index, batch_index, end_of_step);
                        fail_count++;
                    end
                end
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_USE_BIAS:    use_bias_r = cfg_data[0];
                    CFG_HIDDEN_SIZE: hidden_r = cfg_data;
                    CFG_INPUT_SIZE:  input_r = cfg_data;
                    CFG_BATCH_COUNT: batch_r = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                case (cmd)
                    CMD_WX:   wx_mem[index] = value;
                    CMD_WH:   wh_mem[index] = value;
                    CMD_BIAS: if (index < 128) bias_mem[index] = value;
                    CMD_H0:   if (index < 64) h_mem[index] = value;
                    CMD_C0:   if (index < 64) c_mem[index] = value;
                    CMD_X:
                    begin
                        if (index < 64) x_mem[index] = value;
                        if (last) run_step();
                    end
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives weight, state and x items into the lstm layer block over several
// size and bias settings, with random sender gaps, and reports the verdict
// from the checker's failure count.
// ----------------------------------------------------------------------------
module tb;
    import lstm_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam logic [2:0] CFG_SPARE   = 3'd5;

    logic               clk;
    logic               rst_n;
    logic               cfg_write;
    logic [2:0]         cfg_index;
    logic [5:0]         cfg_data;
    logic               start;
    logic               busy;
    logic [2:0]         cmd;
    logic [11:0]        index;
    logic signed [15:0] value;
    logic               last;
    logic               valid;
    logic signed [15:0] hidden_value;
    logic [4:0]         unit_index;
    logic               batch_index;
    logic               end_of_step;
    int                 fail_count;
    int                 pending;

    int idle_pct;
    int cur_h, cur_i, cur_b;
    int amp;

    lstm_layer_forward uut (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .cmd(cmd), .index(index),
        .value(value), .last(last), .valid(valid), .hidden_value(hidden_value),
        .unit_index(unit_index), .batch_index(batch_index), .end_of_step(end_of_step)
    );

    lstm_checker chk (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .start(start), .busy(busy), .cmd(cmd), .index(index),
        .value(value), .last(last), .valid(valid), .hidden_value(hidden_value),
        .unit_index(unit_index), .batch_index(batch_index), .end_of_step(end_of_step),
        .fail_count(fail_count), .pending(pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end

    // one item, then an optional sender gap
    task automatic send(input logic [2:0] c, input int idx, input int v, input logic l);
        start <= 1'b1;
        cmd <= c;
        index <= 12'(idx);
        value <= 16'(v);
        last <= l;
        while (busy) @(negedge clk);
        @(posedge clk);
        @(negedge clk);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
    endtask

    // wait for the block to go quiet, then write a register
    task automatic write_reg(input logic [2:0] r, input logic [5:0] d);
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic int rand_val();
        if (amp == 0) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(2 * amp)) - amp;
    endfunction

    // one phase: sizes, full weight load, some steps with noise mixed in
    task automatic run_phase(input int hs, input int is, input int bs, input logic ub);
        int nsteps;
        write_reg(CFG_USE_BIAS, 6'(ub));
        write_reg(CFG_HIDDEN_SIZE, 6'(hs));
        write_reg(CFG_INPUT_SIZE, 6'(is));
        write_reg(CFG_BATCH_COUNT, 6'(bs));
        cur_h = hs == 0 ? 1 : (hs > 32 ? 32 : hs);
        cur_i = is == 0 ? 1 : (is > 32 ? 32 : is);
        cur_b = bs == 0 ? 1 : (bs > 2 ? 2 : bs);
        amp = $urandom_range(2) == 0 ? 0 : (1 << $urandom_range(8, 13));
        for (int k = 0; k < 4 * cur_h * cur_i; k++)
            send(CMD_WX, k, rand_val(), 1'($urandom_range(1)));
        for (int k = 0; k < 4 * cur_h * cur_h; k++)
            send(CMD_WH, k, rand_val(), 1'($urandom_range(1)));
        for (int k = 0; k < 4 * cur_h; k++)
            send(CMD_BIAS, k, rand_val(), 1'($urandom_range(1)));
        if ($urandom_range(1))
        begin
            for (int k = 0; k < cur_h * cur_b; k++)
            begin
                send(CMD_H0, k, rand_val(), 1'b0);
                send(CMD_C0, k, rand_val(), 1'b0);
            end
        end
        nsteps = $urandom_range(2, 5);
        for (int s = 0; s < nsteps; s++)
        begin
            for (int k = 0; k < cur_i * cur_b; k++)
            begin
                // noise: spare commands and writes beyond a store
                case ($urandom_range(19))
                    0: send(CMD_SPARE_A, $urandom_range(4095), rand_val(), 1'b1);
                    1: send(CMD_SPARE_B, $urandom_range(4095), rand_val(), 1'b1);
                    2: send(CMD_BIAS, $urandom_range(128, 4095), rand_val(), 1'b0);
                    3: send(CMD_H0, $urandom_range(64, 4095), rand_val(), 1'b1);
                    default: ;
                endcase
                send(CMD_X, k, rand_val(), k == cur_i * cur_b - 1);
            end
        end
    endtask

    // stimulus
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        start = 1'b0;
        cmd = CMD_WX;
        index = '0;
        value = '0;
        last = 1'b0;
        idle_pct = 28;
        amp = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: smallest sizes, zero sizes clamp to one
        write_reg(CFG_SPARE, 6'h3f);
        write_reg(CFG_HIDDEN_SIZE, 6'd0);
        write_reg(CFG_INPUT_SIZE, 6'd1);
        write_reg(CFG_BATCH_COUNT, 6'd0);
        write_reg(CFG_USE_BIAS, 6'd1);
        send(CMD_WX, 0, 32767, 1'b0);
        send(CMD_WX, 1, -32768, 1'b0);
        send(CMD_WX, 2, 4096, 1'b0);
        send(CMD_WX, 3, -1, 1'b0);
        send(CMD_WH, 0, -32768, 1'b0);
        send(CMD_WH, 1, 32767, 1'b0);
        send(CMD_WH, 2, 0, 1'b0);
        send(CMD_WH, 3, 4096, 1'b0);
        send(CMD_BIAS, 0, 32767, 1'b0);
        send(CMD_BIAS, 1, -32768, 1'b0);
        send(CMD_BIAS, 2, 1, 1'b0);
        send(CMD_BIAS, 3, -4096, 1'b0);
        send(CMD_H0, 0, 32767, 1'b0);
        send(CMD_C0, 0, -32768, 1'b1);
        send(CMD_SPARE_A, 4095, -1, 1'b1);
        send(CMD_SPARE_B, 0, 0, 1'b1);
        send(CMD_BIAS, 4095, 32767, 1'b0);
        send(CMD_H0, 64, 1, 1'b0);
        send(CMD_X, 63, 32767, 1'b0);
        send(CMD_X, 0, 32767, 1'b1);
        send(CMD_X, 0, -32768, 1'b1);
        send(CMD_X, 0, 0, 1'b1);
        write_reg(CFG_USE_BIAS, 6'd0);
        send(CMD_X, 0, 2048, 1'b1);

        // random phases: sender gaps 28 percent, then 88, then none
        for (int ph = 0; ph < 6; ph++)
        begin
            idle_pct = ph < 2 ? 28 : (ph < 4 ? 88 : 0);
            if (ph == 4)
                run_phase(2, 2, 3, 1'b1);
            else
                run_phase($urandom_range(1, 2), $urandom_range(1, 3),
                          $urandom_range(1, 2), 1'($urandom_range(1)));
        end

        // drain
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lstm_pkg.sv
rtl/core/lstm_layer_forward.sv
sim/lstm_checker.sv
sim/tb.sv
